FILE: design/frt_pkg.sv
// Shared types and constants for the face refinement template block.
// Used by frt_template and face_refinement_template; no dependencies.
package frt_pkg;

    localparam int VERT_W = 4;

    // Local vertex codes: corners 0..3, edge midpoints 4..7, face center 8.
    localparam logic [1:0] CODE_CORNER_HI = 2'b00;
    localparam logic [1:0] CODE_EDGE_HI   = 2'b01;
    localparam logic [VERT_W-1:0] CODE_CENTER = 4'd8;

    localparam logic KIND_TRI  = 1'b0;
    localparam logic KIND_QUAD = 1'b1;

    typedef struct packed {
        logic              kind;
        logic [VERT_W-1:0] a;
        logic [VERT_W-1:0] b;
        logic [VERT_W-1:0] c;
        logic [VERT_W-1:0] d;
        logic              made;
    } face_t;

    function automatic logic [VERT_W-1:0] corner_code(input logic [1:0] idx);
        return {CODE_CORNER_HI, idx};
    endfunction

    function automatic logic [VERT_W-1:0] edge_code(input logic [1:0] idx);
        return {CODE_EDGE_HI, idx};
    endfunction

    function automatic face_t mk_tri(input logic [VERT_W-1:0] a,
                                     input logic [VERT_W-1:0] b,
                                     input logic [VERT_W-1:0] c);
        face_t f;
        f.kind = KIND_TRI;
        f.a    = a;
        f.b    = b;
        f.c    = c;
        f.d    = '0;
        f.made = 1'b0;
        return f;
    endfunction

    function automatic face_t mk_quad(input logic [VERT_W-1:0] a,
                                      input logic [VERT_W-1:0] b,
                                      input logic [VERT_W-1:0] c,
                                      input logic [VERT_W-1:0] d);
        face_t f;
        f.kind = KIND_QUAD;
        f.a    = a;
        f.b    = b;
        f.c    = c;
        f.d    = d;
        f.made = 1'b0;
        return f;
    endfunction

endpackage

FILE: design/frt_template.sv
// Combinational refinement templates: maps one face description to its list
// of sub-faces. Depends on frt_pkg.
module frt_template (
    input  logic                 is_quad,
    input  logic [3:0]           edge_marks,
    input  logic                 has_center,
    input  logic [2:0]           snap_corner,
    output frt_pkg::face_t [3:0] faces,
    output logic [1:0]           last_idx,
    output logic                 err
);
    import frt_pkg::*;

    // Addition modulo three on corner indexes of a triangle.
    function automatic logic [1:0] add3(input logic [1:0] x, input logic [1:0] k);
        logic [2:0] s;
        s = {1'b0, x} + {1'b0, k};
        return (s >= 3'd3) ? 2'(s - 3'd3) : s[1:0];
    endfunction

    logic [2:0] tmarks;
    logic [1:0] tri_n;
    logic [1:0] tri_e;
    logic [1:0] tri_f;
    logic [2:0] quad_n;
    logic [1:0] qe0;
    logic [1:0] qe1;
    logic [1:0] qf;
    logic       snap_valid;

    // Pattern decode: lowest split edge, second split edge, lowest unsplit edge.
    always_comb begin
        tmarks = edge_marks[2:0];
        tri_n  = 2'($countones(tmarks));
        quad_n = 3'($countones(edge_marks));
        tri_e  = tmarks[0] ? 2'd0 : (tmarks[1] ? 2'd1 : 2'd2);
        tri_f  = !tmarks[0] ? 2'd0 : (!tmarks[1] ? 2'd1 : 2'd2);
        qe0    = edge_marks[0] ? 2'd0 : edge_marks[1] ? 2'd1 :
                 edge_marks[2] ? 2'd2 : 2'd3;
        qe1    = (edge_marks[1] && qe0 < 2'd1) ? 2'd1 :
                 (edge_marks[2] && qe0 < 2'd2) ? 2'd2 : 2'd3;
        qf     = !edge_marks[0] ? 2'd0 : !edge_marks[1] ? 2'd1 :
                 !edge_marks[2] ? 2'd2 : 2'd3;
        snap_valid = (snap_corner <= 3'd3);
    end

    always_comb begin
        logic [1:0]        c0, c1, c2, c3, ea, eb, ii;
        logic [VERT_W-1:0] m, ma, mb, m0, m1, m2;
        logic              ok;
        faces    = '0;
        last_idx = 2'd0;
        err      = 1'b0;
        c0 = '0; c1 = '0; c2 = '0; c3 = '0; ea = '0; eb = '0; ii = '0;
        m = '0; ma = '0; mb = '0; m0 = '0; m1 = '0; m2 = '0;
        ok = 1'b0;
        if (!is_quad) begin
            if (has_center) begin
                if (tri_n != 2'd0) begin
                    err = 1'b1;
                end else begin
                    faces[0] = mk_tri(corner_code(2'd0), corner_code(2'd1), CODE_CENTER);
                    faces[1] = mk_tri(corner_code(2'd1), corner_code(2'd2), CODE_CENTER);
                    faces[2] = mk_tri(corner_code(2'd2), corner_code(2'd0), CODE_CENTER);
                    last_idx = 2'd2;
                end
            end else begin
                case (tri_n)
                    2'd0: begin
                        faces[0] = mk_tri(corner_code(2'd0), corner_code(2'd1),
                                          corner_code(2'd2));
                    end
                    2'd1: begin
                        c0 = add3(tri_e, 2'd2);
                        c1 = add3(c0, 2'd1);
                        c2 = add3(c1, 2'd1);
                        m  = edge_code(tri_e);
                        faces[0] = mk_tri(corner_code(c0), corner_code(c1), m);
                        faces[1] = mk_tri(corner_code(c0), m, corner_code(c2));
                        last_idx = 2'd1;
                    end
                    2'd2: begin
                        ea = add3(tri_f, 2'd1);
                        eb = add3(tri_f, 2'd2);
                        faces[0] = mk_tri(edge_code(ea), corner_code(eb), edge_code(eb));
                        faces[1] = mk_quad(corner_code(tri_f), corner_code(ea),
                                           edge_code(ea), edge_code(eb));
                        last_idx = 2'd1;
                    end
                    default: begin
                        faces[0] = mk_tri(corner_code(2'd0), edge_code(2'd0), edge_code(2'd2));
                        faces[1] = mk_tri(corner_code(2'd1), edge_code(2'd1), edge_code(2'd0));
                        faces[2] = mk_tri(corner_code(2'd2), edge_code(2'd2), edge_code(2'd1));
                        faces[3] = mk_tri(edge_code(2'd0), edge_code(2'd1), edge_code(2'd2));
                        last_idx = 2'd3;
                    end
                endcase
            end
        end else if (quad_n == 3'd0) begin
            if (has_center) begin
                for (int i = 0; i < 4; i++) begin
                    ii = 2'(i);
                    faces[i] = mk_tri(corner_code(ii), corner_code(ii + 2'd1), CODE_CENTER);
                end
                last_idx = 2'd3;
            end else begin
                faces[0] = mk_quad(corner_code(2'd0), corner_code(2'd1),
                                   corner_code(2'd2), corner_code(2'd3));
            end
        end else if (quad_n == 3'd4) begin
            // All edges split: four quads around the center, which may be new.
            for (int i = 0; i < 4; i++) begin
                ii = 2'(i);
                faces[i] = mk_quad(corner_code(ii), edge_code(ii), CODE_CENTER,
                                   edge_code(ii + 2'd3));
                faces[i].made = !has_center;
            end
            last_idx = 2'd3;
        end else if (has_center) begin
            err = 1'b1;
        end else begin
            case (quad_n)
                3'd1: begin
                    c0 = qe0 + 2'd3;
                    c1 = c0 + 2'd1;
                    c2 = c0 + 2'd2;
                    c3 = c0 + 2'd3;
                    m  = edge_code(qe0);
                    // A snap corner at an end of the split edge is ignored.
                    ok = snap_valid && (snap_corner[1:0] != qe0) &&
                         (snap_corner[1:0] != qe0 + 2'd1);
                    if (!ok) begin
                        faces[0] = mk_tri(corner_code(c0), corner_code(c1), m);
                        faces[1] = mk_tri(corner_code(c0), m, corner_code(c3));
                        faces[2] = mk_tri(corner_code(c3), m, corner_code(c2));
                        last_idx = 2'd2;
                    end else if (snap_corner[1:0] == c0) begin
                        faces[0] = mk_tri(corner_code(c0), corner_code(c1), m);
                        faces[1] = mk_quad(corner_code(c0), m, corner_code(c2),
                                           corner_code(c3));
                        last_idx = 2'd1;
                    end else begin
                        faces[0] = mk_quad(corner_code(c0), corner_code(c1), m,
                                           corner_code(c3));
                        faces[1] = mk_tri(corner_code(c3), m, corner_code(c2));
                        last_idx = 2'd1;
                    end
                end
                3'd2: begin
                    if (qe1 - qe0 == 2'd2) begin
                        c0 = qe0 + 2'd3;
                        c1 = c0 + 2'd1;
                        c2 = c0 + 2'd2;
                        c3 = c0 + 2'd3;
                        faces[0] = mk_quad(corner_code(c0), corner_code(c1),
                                           edge_code(qe0), edge_code(qe1));
                        faces[1] = mk_quad(edge_code(qe1), edge_code(qe0),
                                           corner_code(c2), corner_code(c3));
                        last_idx = 2'd1;
                    end else begin
                        // Adjacent edges: ea is followed by eb around the face.
                        if (qe0 + 2'd1 != qe1) begin
                            ea = qe1;
                            eb = qe0;
                        end else begin
                            ea = qe0;
                            eb = qe1;
                        end
                        c0 = ea + 2'd3;
                        c1 = c0 + 2'd1;
                        c2 = c0 + 2'd2;
                        c3 = c0 + 2'd3;
                        ma = edge_code(ea);
                        mb = edge_code(eb);
                        ok = snap_valid && (snap_corner[1:0] == c0);
                        faces[0] = mk_tri(corner_code(c0), corner_code(c1), ma);
                        if (!ok) begin
                            faces[1] = mk_tri(ma, corner_code(c2), mb);
                            faces[2] = mk_tri(corner_code(c3), corner_code(c0), mb);
                            faces[3] = mk_tri(corner_code(c0), ma, mb);
                            last_idx = 2'd3;
                        end else begin
                            faces[1] = mk_tri(corner_code(c3), corner_code(c0), mb);
                            faces[2] = mk_quad(corner_code(c0), ma, corner_code(c2), mb);
                            last_idx = 2'd2;
                        end
                    end
                end
                default: begin
                    c3 = qf;
                    c0 = qf + 2'd1;
                    c1 = qf + 2'd2;
                    c2 = qf + 2'd3;
                    m0 = edge_code(c0);
                    m1 = edge_code(c1);
                    m2 = edge_code(c2);
                    faces[0] = mk_quad(corner_code(c0), m0, m2, corner_code(c3));
                    faces[1] = mk_tri(corner_code(c1), m1, m0);
                    faces[2] = mk_tri(corner_code(c2), m2, m1);
                    faces[3] = mk_tri(m0, m1, m2);
                    last_idx = 2'd3;
                end
            endcase
        end
    end

endmodule

FILE: design/face_refinement_template.sv
// Top level of the face refinement template block: input register, template
// lookup and sub-face output queue. Depends on frt_pkg and frt_template.
//
// Usage. Each item on the s_ channel describes one mesh face: its shape, the
// mask of split edges, whether a center vertex exists and an optional snap
// corner. The block answers on the m_ channel with one item per sub-face of
// the refinement, between one and four, and raises m_last on the final one.
// An unsupported center/edge combination gives a single item with m_status
// set and all corner codes zero.
// The input register takes the face when it is accepted; the queue loads the
// template's sub-faces from it once the queue is free, and the first sub-face
// then appears on m_.
// Throughput: one sub-face per cycle while m_ready is high. The template
// lookup is a single combinational step, so the four-entry output queue sets
// the rate.
// The next face is taken into the input register while the previous one is
// still being emitted and moves on when the queue sends its last sub-face.
// When the receiver holds m_ready low, the queue holds its head, the input
// register fills and s_ready drops. Reset (aresetn low at a clock edge)
// empties both stages; no item is lost or invented across a stall.
module face_refinement_template (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_is_quad,
    input  logic [3:0] s_edge_marks,
    input  logic       s_has_center,
    input  logic [2:0] s_snap_corner,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_face_kind,
    output logic [3:0] m_vert_a,
    output logic [3:0] m_vert_b,
    output logic [3:0] m_vert_c,
    output logic [3:0] m_vert_d,
    output logic       m_status,
    output logic       m_made_center,
    output logic       m_last
);
    import frt_pkg::*;

    // Input register.
    logic       in_valid_reg, in_valid_next;
    logic       in_quad_reg;
    logic [3:0] in_marks_reg;
    logic       in_center_reg;
    logic [2:0] in_snap_reg;

    // Output queue: the head sits in entry 0; remaining count minus one.
    face_t [3:0] q_reg, q_next;
    logic        q_valid_reg, q_valid_next;
    logic [1:0]  q_left_reg, q_left_next;
    logic        q_err_reg, q_err_next;

    face_t [3:0] tmpl_faces;
    logic [1:0]  tmpl_last_idx;
    logic        tmpl_err;

    logic s_take;
    logic m_take;
    logic q_done;
    logic q_load;

    frt_template u_template (
        .is_quad    (in_quad_reg),
        .edge_marks (in_marks_reg),
        .has_center (in_center_reg),
        .snap_corner(in_snap_reg),
        .faces      (tmpl_faces),
        .last_idx   (tmpl_last_idx),
        .err        (tmpl_err)
    );

    assign m_take  = m_valid && m_ready;
    // The queue frees up when it is empty or its last sub-face leaves now.
    assign q_done  = !q_valid_reg || (m_take && q_left_reg == 2'd0);
    assign q_load  = in_valid_reg && q_done;
    assign s_ready = !in_valid_reg || q_load;
    assign s_take  = s_valid && s_ready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_take) begin
            in_valid_next = 1'b1;
        end else if (q_load) begin
            in_valid_next = 1'b0;
        end
    end

    always_comb begin
        q_next       = q_reg;
        q_valid_next = q_valid_reg;
        q_left_next  = q_left_reg;
        q_err_next   = q_err_reg;
        if (q_load) begin
            q_next       = tmpl_faces;
            q_valid_next = 1'b1;
            q_left_next  = tmpl_last_idx;
            q_err_next   = tmpl_err;
        end else if (q_done) begin
            q_valid_next = 1'b0;
        end else if (m_take) begin
            q_next      = {face_t'('0), q_reg[3:1]};
            q_left_next = q_left_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            q_valid_reg  <= 1'b0;
            q_left_reg   <= 2'd0;
        end else begin
            in_valid_reg <= in_valid_next;
            q_valid_reg  <= q_valid_next;
            q_left_reg   <= q_left_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_take) begin
            in_quad_reg   <= s_is_quad;
            in_marks_reg  <= s_edge_marks;
            in_center_reg <= s_has_center;
            in_snap_reg   <= s_snap_corner;
        end
        q_reg     <= q_next;
        q_err_reg <= q_err_next;
    end

    assign m_valid       = q_valid_reg;
    assign m_face_kind   = q_reg[0].kind;
    assign m_vert_a      = q_reg[0].a;
    assign m_vert_b      = q_reg[0].b;
    assign m_vert_c      = q_reg[0].c;
    assign m_vert_d      = q_reg[0].d;
    assign m_status      = q_err_reg;
    assign m_made_center = q_reg[0].made;
    assign m_last        = (q_left_reg == 2'd0);

`ifndef ASSERT_OFF
    // An error answer is always a single item.
    a_err_single: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status |-> m_last)
        else $error("error item not marked last");

    // A taken non-final sub-face is followed by the next one of the same face.
    a_no_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last |=> m_valid && !m_status)
        else $error("sub-face sequence broken");

    // Triangles carry no fourth corner.
    a_tri_d: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_face_kind == KIND_TRI |-> m_vert_d == '0)
        else $error("triangle with fourth corner");

    // A stalled queue stays valid and keeps its remaining count.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(q_left_reg))
        else $error("output queue moved while stalled");
`endif

endmodule
